// File: hdl/art_pkg.sv
// ----------------------------------------------------------------------------
// art_pkg: shared types and constants for the address region table
// Operation codes, table geometry, config register indexes and the
// command/status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package art_pkg;

  localparam int unsigned MaxRegions = 16;
  localparam int unsigned SlotW      = $clog2(MaxRegions);
  localparam int unsigned CntW       = $clog2(MaxRegions + 2);
  localparam int unsigned PageShift  = 12;
  localparam int unsigned PageW      = 64 - PageShift;

  localparam logic [63:0] PgMask    = 64'h0000_0000_0000_0FFF;
  localparam logic [63:0] HeapGuard = 64'h0000_0000_0400_0000;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_FIND   = 3'd2,
    OP_FREE   = 3'd3,
    OP_RANGE  = 3'd4
  } op_t;

  typedef enum logic [0:0] {
    CFG_MMAP_START = 1'b0,
    CFG_HEAP_END   = 1'b1
  } cfg_idx_t;

  typedef logic [SlotW-1:0] slot_t;
  typedef logic [PageW-1:0] page_t;

  // datapath commands issued by the controller
  typedef struct packed {
    logic  load;        // latch input item
    logic  rd;          // read slot rd_idx
    slot_t rd_idx;
    logic  scan_eval;   // evaluate slot read last cycle (data valid)
    logic  scan_clr;    // clear per-scan trackers
    logic  add_commit;
    logic  rm_apply;    // apply remove action to scanned slot
    logic  split_wr;    // write second half of a split
    logic  ff_setup;    // compute len/lower
    logic  ff_next;     // advance search or set hint after a pass
    logic  rg_setup;
    logic  rg_next;
    logic  find_take;   // hit capture request; not driven or used
  } dp_cmd_t;

  typedef struct packed {
    logic  ff_bad;      // free search setup fails
    logic  ff_below;    // search position under lower bound
    logic  scan_hit;    // scan found a slot
    logic  add_ok;      // no overlap seen, aligned, nonempty
    logic  have_free;
    logic  rm_empty;    // remove with start >= end
    logic  rm_split;    // scanned slot needs a split
    logic  rm_touch;    // scanned slot overlapped
    logic  rg_zero;
    logic  rg_wrap;
    logic  rg_done;     // cur passed last
  } dp_sts_t;

endpackage

// File: hdl/art_if.sv
// ----------------------------------------------------------------------------
// art_if: valid/ready channel carrying one payload
// Generic stream interface used for the input and result channels.
// ----------------------------------------------------------------------------
interface art_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/address_region_table.sv
// ----------------------------------------------------------------------------
// address_region_table: page-aligned region table with five operations
// Each item runs one operation and gives one result. Add and find walk the
// slots one per cycle through a registered-read slot memory; remove reads
// each slot, then acts on it; find-free and range-check repeat the walk up
// to MaxRegions+2 (resp. MaxRegions+1) times. Only one item is in flight;
// the result holds until taken.
// ----------------------------------------------------------------------------
module address_region_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_idx,
  input  logic [63:0] cfg_data,
  art_if.sink         in_ch,
  art_if.source       out_ch
);
  art_pkg::dp_cmd_t cmd;
  art_pkg::dp_sts_t sts;
  logic [2:0]  op_q;
  logic [63:0] res_addr, res_end;
  logic [31:0] res_flags;
  logic ok, zero, find;

  art_datapath u_dp (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data,
    .in_op(in_ch.payload.operation), .in_addr(in_ch.payload.address),
    .in_end(in_ch.payload.end_address), .in_len(in_ch.payload.length),
    .in_flags(in_ch.payload.region_flags),
    .cmd, .sts, .op_q, .res_addr, .res_end, .res_flags);

  art_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_op(in_ch.payload.operation), .out_valid(out_ch.valid),
    .out_ready(out_ch.ready), .out_ok(ok), .out_zero(zero), .out_find(find),
    .op_q, .cmd, .sts);

  assign out_ch.payload.success        = ok;
  assign out_ch.payload.result_address = zero ? 64'd0 : res_addr;
  assign out_ch.payload.hit_end        = find ? res_end : 64'd0;
  assign out_ch.payload.hit_flags      = find ? res_flags : 32'd0;
endmodule

// File: hdl/art_ram.sv
// ----------------------------------------------------------------------------
// art_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module art_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/art_datapath.sv
// ----------------------------------------------------------------------------
// art_datapath: slot storage and arithmetic for the region table
// Holds the slot RAMs, valid bits, config registers, the latched item and
// the per-scan compare logic. Works under the controller, one slot at a time.
// ----------------------------------------------------------------------------
module art_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_idx,
  input  logic [63:0]       cfg_data,
  input  logic [2:0]        in_op,
  input  logic [63:0]       in_addr,
  input  logic [63:0]       in_end,
  input  logic [63:0]       in_len,
  input  logic [31:0]       in_flags,
  input  art_pkg::dp_cmd_t  cmd,
  output art_pkg::dp_sts_t  sts,
  output logic [2:0]        op_q,
  output logic [63:0]       res_addr,
  output logic [63:0]       res_end,
  output logic [31:0]       res_flags
);
  localparam int unsigned Ps = art_pkg::PageShift;
  localparam int unsigned Pw = art_pkg::PageW;

  logic [63:0] mmap_start_r, heap_end_r, hint_r;
  logic [2:0]  op_r;
  logic [63:0] a_r, e_r, len_r, lower_r, cand_r;
  logic [63:0] srch_r;   // search position of the running free search
  logic [31:0] fl_r;
  logic [art_pkg::MaxRegions-1:0] valid_r;
  logic ff_bad_r;

  // scan trackers
  logic                 hit_r;
  art_pkg::slot_t       hit_idx_r;
  art_pkg::page_t       hit_sp_r, hit_ep_r;
  logic [31:0]          hit_fl_r;
  logic                 ovl_r;

  // last slot read
  art_pkg::slot_t rd_q_r;
  art_pkg::page_t sp_rd, ep_rd;
  logic [31:0]    fl_rd;

  // write port
  logic           we;
  art_pkg::slot_t waddr;
  art_pkg::page_t wsp, wep;
  logic [31:0]    wfl;

  // free slot
  logic           have_free;
  art_pkg::slot_t free_idx;
  always_comb begin
    have_free = 1'b0;
    free_idx  = '0;
    for (int i = art_pkg::MaxRegions - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        have_free = 1'b1;
        free_idx  = art_pkg::slot_t'(i);
      end
    end
  end

  art_ram #(.Width(Pw), .Depth(art_pkg::MaxRegions)) u_sp (
    .clk, .we, .waddr, .wdata(wsp), .raddr(cmd.rd_idx), .rdata(sp_rd));
  art_ram #(.Width(Pw), .Depth(art_pkg::MaxRegions)) u_ep (
    .clk, .we, .waddr, .wdata(wep), .raddr(cmd.rd_idx), .rdata(ep_rd));
  art_ram #(.Width(32), .Depth(art_pkg::MaxRegions)) u_fl (
    .clk, .we, .waddr, .wdata(wfl), .raddr(cmd.rd_idx), .rdata(fl_rd));

  // item-derived page numbers
  art_pkg::page_t sp_in, ep_add, ep_rm, cur_r, last_pg;
  assign sp_in  = a_r[63:Ps];
  assign ep_add = e_r[63:Ps];
  logic [Pw:0] ep_rm_w;
  assign ep_rm_w = {1'b0, e_r[63:Ps]} + {{Pw{1'b0}}, |(e_r & art_pkg::PgMask)};
  assign ep_rm   = ep_rm_w[Pw-1:0];
  logic [64:0] a_plus_len;
  assign a_plus_len = {1'b0, a_r} + {1'b0, len_r};
  logic [63:0] a_end_m1;
  assign a_end_m1 = a_r + len_r - 64'd1;
  assign last_pg  = a_end_m1[63:Ps];

  logic [63:0] slot_s_b, slot_e_b, cend;
  assign slot_s_b = {sp_rd, {Ps{1'b0}}};
  assign slot_e_b = {ep_rd, {Ps{1'b0}}};
  assign cend     = cand_r + len_r;

  // per-slot match for the current operation, slot data just read
  logic v_rd, m_find, m_add, m_ff, m_rm;
  logic [Pw:0] ep_rm_cmp;
  assign v_rd   = valid_r[rd_q_r];
  assign m_find = v_rd && (sp_rd <= cur_r) && (cur_r < ep_rd);
  assign m_add  = v_rd && (sp_in < ep_rd) && (ep_add > sp_rd);
  assign m_ff   = v_rd && (cand_r < slot_e_b) && (cend > slot_s_b);
  assign ep_rm_cmp = ep_rm_w;
  assign m_rm   = v_rd && ({1'b0, sp_rd} < ep_rm_cmp) && (ep_rd > sp_in);

  logic scan_match;
  always_comb begin
    case (op_r)
      art_pkg::OP_ADD:  scan_match = m_add;
      art_pkg::OP_FREE: scan_match = m_ff;
      default:          scan_match = m_find;
    endcase
  end

  logic in_inside, in_left;
  assign in_inside = (sp_rd >= sp_in) && ({1'b0, ep_rd} <= ep_rm_cmp);
  assign in_left   = sp_rd < sp_in;

  // find free setup
  logic [63:0] len_up, guard;
  logic [64:0] lower_w;
  assign len_up  = (len_r + art_pkg::PgMask) & ~art_pkg::PgMask;
  assign guard   = heap_end_r + art_pkg::HeapGuard;
  assign lower_w = {1'b0, guard} + {1'b0, len_up};

  // writes
  always_comb begin
    we    = 1'b0;
    waddr = free_idx;
    wsp   = sp_in;
    wep   = ep_add;
    wfl   = fl_r;
    if (cmd.add_commit) begin
      we = 1'b1;
    end else if (cmd.split_wr) begin
      we = 1'b1;
      wsp = ep_rm;
      wep = ep_rd;
      wfl = fl_rd;
    end else if (cmd.rm_apply && m_rm && !in_inside) begin
      we    = 1'b1;
      waddr = rd_q_r;
      wfl   = fl_rd;
      if (in_left) begin
        wsp = sp_rd;
        wep = sp_in;
      end else begin
        wsp = ep_rm;
        wep = ep_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mmap_start_r <= 64'd139637976727552;
      heap_end_r   <= '0;
      hint_r       <= 64'd139637976727552;
      valid_r      <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == art_pkg::CFG_MMAP_START) begin
          mmap_start_r <= cfg_data;
          hint_r       <= cfg_data;
        end else begin
          heap_end_r <= cfg_data;
        end
      end
      if (cmd.add_commit) valid_r[free_idx] <= 1'b1;
      if (cmd.split_wr) valid_r[free_idx] <= 1'b1;
      if (cmd.rm_apply && m_rm && in_inside) valid_r[rd_q_r] <= 1'b0;
      // the hint moves on a found gap and on an mmap start write
      if (cmd.ff_next && !hit_r) hint_r <= cand_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_q_r <= cmd.rd_idx;
    if (cmd.load) begin
      op_r  <= in_op;
      a_r   <= in_addr;
      e_r   <= in_end;
      len_r <= in_len;
      fl_r  <= in_flags;
      cur_r <= in_addr[63:Ps];
    end
    if (cmd.ff_setup) begin
      ff_bad_r <= (len_r == 64'd0) || (len_r > ~art_pkg::PgMask)
                  || (heap_end_r > ~art_pkg::HeapGuard)
                  || lower_w[64];
      lower_r <= lower_w[63:0];
      len_r   <= len_up;
      srch_r  <= hint_r;
      cand_r  <= (hint_r - len_up) & ~art_pkg::PgMask;
    end
    if (cmd.ff_next) begin
      if (hit_r) begin
        srch_r <= {hit_sp_r, {Ps{1'b0}}};
        cand_r <= ({hit_sp_r, {Ps{1'b0}}} - len_r) & ~art_pkg::PgMask;
      end
    end
    if (cmd.rg_next) cur_r <= hit_ep_r;
    if (cmd.scan_clr) begin
      hit_r <= 1'b0;
      ovl_r <= 1'b0;
    end else if (cmd.scan_eval) begin
      if (scan_match) ovl_r <= 1'b1;
      if (scan_match && (!hit_r || (op_r == art_pkg::OP_FREE && sp_rd < hit_sp_r))) begin
        hit_r     <= 1'b1;
        hit_idx_r <= rd_q_r;
        hit_sp_r  <= sp_rd;
        hit_ep_r  <= ep_rd;
        hit_fl_r  <= fl_rd;
      end
    end
  end

  assign sts.ff_bad    = ff_bad_r;
  assign sts.ff_below  = srch_r < lower_r;
  assign sts.scan_hit  = hit_r;
  assign sts.add_ok    = !ovl_r && (a_r < e_r) && ((a_r & art_pkg::PgMask) == 64'd0)
                         && ((e_r & art_pkg::PgMask) == 64'd0);
  assign sts.have_free = have_free;
  assign sts.rm_empty  = a_r >= e_r;
  assign sts.rm_split  = m_rm && in_left && ({1'b0, ep_rd} > ep_rm_cmp);
  assign sts.rm_touch  = m_rm;
  assign sts.rg_zero   = len_r == 64'd0;
  assign sts.rg_wrap   = a_plus_len[64];
  assign sts.rg_done   = cur_r > last_pg;

  assign op_q      = op_r;
  assign res_addr  = (op_r == art_pkg::OP_FREE) ? cand_r : {hit_sp_r, {Ps{1'b0}}};
  assign res_end   = {hit_ep_r, {Ps{1'b0}}};
  assign res_flags = hit_fl_r;

  logic unused_ok;
  assign unused_ok = ^{mmap_start_r, hit_idx_r, cmd.find_take, cmd.rg_setup};
endmodule

// File: hdl/art_ctrl.sv
// ----------------------------------------------------------------------------
// art_ctrl: operation sequencer for the region table
// Walks the slots, one per cycle or, for remove, reading then acting on
// each, decides each operation's outcome and drives the result register.
// ----------------------------------------------------------------------------
module art_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       in_op,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_ok,
  output logic             out_zero,   // zero address unless hit or gap
  output logic             out_find,
  input  logic [2:0]       op_q,
  output art_pkg::dp_cmd_t cmd,
  input  art_pkg::dp_sts_t sts
);
  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SCAN, S_LAST, S_DECIDE, S_RM_WAIT, S_FF_CHECK, S_OUT
  } state_t;

  state_t         state_r, state_nxt;
  art_pkg::slot_t idx_r, idx_nxt;
  logic [art_pkg::CntW-1:0] iter_r, iter_nxt;
  logic           ok_r, ok_nxt, zero_r, zero_nxt, find_r, find_nxt;
  logic           did_r, did_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_ok    = ok_r;
  assign out_zero  = zero_r;
  assign out_find  = find_r;

  localparam art_pkg::slot_t LastSlot = art_pkg::slot_t'(art_pkg::MaxRegions - 1);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    iter_nxt  = iter_r;
    ok_nxt    = ok_r;
    zero_nxt  = zero_r;
    find_nxt  = find_r;
    did_nxt   = did_r;
    cmd       = '0;
    cmd.rd_idx = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        idx_nxt  = '0;
        iter_nxt = '0;
        did_nxt  = 1'b0;
        ok_nxt   = 1'b0;
        zero_nxt = 1'b1;
        find_nxt = 1'b0;
        cmd.scan_clr = 1'b1;
        cmd.rd_idx   = '0;
        case (op_q) inside
          art_pkg::OP_ADD, art_pkg::OP_FIND: begin
            state_nxt = S_SCAN;
          end
          art_pkg::OP_REMOVE: begin
            if (sts.rm_empty) state_nxt = S_OUT;
            else state_nxt = S_SCAN;
          end
          art_pkg::OP_FREE: begin
            cmd.ff_setup = 1'b1;
            state_nxt    = S_FF_CHECK;
          end
          art_pkg::OP_RANGE: begin
            if (sts.rg_zero) begin
              ok_nxt = 1'b1;
              state_nxt = S_OUT;
            end else if (sts.rg_wrap) begin
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_FF_CHECK: begin
        cmd.scan_clr = 1'b1;
        cmd.rd_idx   = '0;
        idx_nxt      = '0;
        if (sts.ff_bad || sts.ff_below ||
            iter_r == art_pkg::CntW'(art_pkg::MaxRegions + 2)) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // if not remove, RAM holds slot idx_r, read in the previous cycle
        cmd.scan_eval = (op_q != art_pkg::OP_REMOVE);
        if (op_q == art_pkg::OP_REMOVE) begin
          // one slot at a time: read, then act
          state_nxt = S_RM_WAIT;
        end else if (idx_r == LastSlot) begin
          state_nxt = S_LAST;
        end else begin
          idx_nxt    = idx_r + 1'b1;
          cmd.rd_idx = idx_r + 1'b1;
        end
      end
      S_RM_WAIT: begin
        cmd.rd_idx = idx_r;
        if (sts.rm_touch) did_nxt = 1'b1;
        if (sts.rm_split) begin
          if (sts.have_free) begin
            cmd.split_wr = 1'b1;
            state_nxt    = S_DECIDE;   // trim left part next cycle
          end else begin
            state_nxt = (idx_r == LastSlot) ? S_OUT : S_SCAN;
            idx_nxt   = idx_r + 1'b1;
            ok_nxt    = 1'b1;
          end
        end else begin
          cmd.rm_apply = 1'b1;
          if (idx_r == LastSlot) begin
            ok_nxt    = did_r | sts.rm_touch;
            state_nxt = S_OUT;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end
      S_LAST: begin
        cmd.scan_eval = 1'b1;
        state_nxt     = S_DECIDE;
      end
      S_DECIDE: begin
        case (op_q)
          art_pkg::OP_REMOVE: begin
            // trim left after split write; RAM output still holds the slot
            cmd.rm_apply = 1'b1;
            did_nxt      = 1'b1;
            if (idx_r == LastSlot) begin
              ok_nxt    = 1'b1;
              state_nxt = S_OUT;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = S_SCAN;
            end
          end
          art_pkg::OP_ADD: begin
            if (sts.add_ok && sts.have_free) begin
              cmd.add_commit = 1'b1;
              ok_nxt         = 1'b1;
            end
            state_nxt = S_OUT;
          end
          art_pkg::OP_FIND: begin
            ok_nxt    = sts.scan_hit;
            zero_nxt  = !sts.scan_hit;
            find_nxt  = sts.scan_hit;
            state_nxt = S_OUT;
          end
          art_pkg::OP_FREE: begin
            cmd.ff_next = 1'b1;
            iter_nxt    = iter_r + 1'b1;
            if (!sts.scan_hit) begin
              ok_nxt    = 1'b1;
              zero_nxt  = 1'b0;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_FF_CHECK;
            end
          end
          default: begin
            // range check
            iter_nxt = iter_r + 1'b1;
            if (!sts.scan_hit) begin
              state_nxt = S_OUT;
            end else begin
              cmd.rg_next = 1'b1;
              if (iter_r == art_pkg::CntW'(art_pkg::MaxRegions)) begin
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_FF_CHECK;
              end
            end
          end
        endcase
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // range check: after advancing cur, decide done or rescan
    if (state_r == S_FF_CHECK && op_q == art_pkg::OP_RANGE) begin
      cmd.scan_clr = 1'b1;
      if (sts.rg_done) begin
        ok_nxt    = 1'b1;
        state_nxt = S_OUT;
      end else begin
        state_nxt = S_SCAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      iter_r  <= '0;
      ok_r    <= 1'b0;
      zero_r  <= 1'b1;
      find_r  <= 1'b0;
      did_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      iter_r  <= iter_nxt;
      ok_r    <= ok_nxt;
      zero_r  <= zero_nxt;
      find_r  <= find_nxt;
      did_r   <= did_nxt;
    end
  end

  logic unused_ok;
  assign unused_ok = ^in_op;

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DISPATCH))
    else $error("accepted item did not dispatch");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(ok_r)))
    else $error("result dropped while stalled");
  a_find_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && find_r) |-> ok_r)
    else $error("find payload without hit");
endmodule

// File: test/region_tb_pkg.sv
// ----------------------------------------------------------------------------
// region_tb_pkg: transfer payload types for the region table bench
// Request and response layouts that are shared by the stimulus top and the
// checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package region_tb_pkg;

  typedef struct packed {
    logic [2:0]  operation;
    logic [63:0] address;
    logic [63:0] end_address;
    logic [63:0] length;
    logic [31:0] region_flags;
  } region_req_t;

  typedef struct packed {
    logic        success;
    logic [63:0] result_address;
    logic [63:0] hit_end;
    logic [31:0] hit_flags;
  } region_rsp_t;

  localparam logic [2:0] OP_BAD_LO = 3'd5;
  localparam logic [2:0] OP_BAD_HI = 3'd7;

endpackage

// File: test/region_checker.sv
// ----------------------------------------------------------------------------
// region_checker: response predictor and scoreboard for the region table
// Tracks config writes and accepted requests, keeps a shadow copy of the
// region slots and the mmap hint, and compares each response transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module region_checker
  import art_pkg::*;
  import region_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_idx,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  region_req_t in_item,
  input  logic        out_valid,
  input  logic        out_ready,
  input  region_rsp_t out_item,
  output int          fails,
  output int          pending
);

  localparam logic [63:0] AllOnes = '1;

  logic [63:0] start_pg [MaxRegions];
  logic [63:0] end_pg   [MaxRegions];
  logic [31:0] flags_q  [MaxRegions];
  logic        used     [MaxRegions];
  logic [63:0] mmap_start_q, heap_end_q, hint_q;

  region_rsp_t want_q[$];

  assign pending = want_q.size();

  function automatic int first_free();
    for (int i = 0; i < MaxRegions; i++)
      if (!used[i]) return i;
    return -1;
  endfunction

  function automatic int owner_of(input logic [63:0] pg);
    for (int i = 0; i < MaxRegions; i++)
      if (used[i] && start_pg[i] <= pg && pg < end_pg[i]) return i;
    return -1;
  endfunction

  function automatic bit region_add(input logic [63:0] s, e, input logic [31:0] fl);
    logic [63:0] sp, ep;
    int f;
    if (s >= e || (s & PgMask) != 0 || (e & PgMask) != 0) return 0;
    sp = s >> PageShift;
    ep = e >> PageShift;
    for (int i = 0; i < MaxRegions; i++)
      if (used[i] && sp < end_pg[i] && ep > start_pg[i]) return 0;
    f = first_free();
    if (f < 0) return 0;
    start_pg[f] = sp;
    end_pg[f]   = ep;
    flags_q[f]  = fl;
    used[f]     = 1'b1;
    return 1;
  endfunction

  function automatic bit region_remove(input logic [63:0] s, e);
    logic        seen [MaxRegions];
    logic [63:0] sp, ep, vs, ve;
    int f;
    bit did;
    did = 0;
    if (s >= e) return 0;
    sp = s >> PageShift;
    ep = (e >> PageShift) + (((e & PgMask) != 0) ? 64'd1 : 64'd0);
    seen = used;
    for (int i = 0; i < MaxRegions; i++) begin
      if (!seen[i]) continue;
      vs = start_pg[i];
      ve = end_pg[i];
      if (vs >= ep || ve <= sp) continue;
      did = 1;
      if (vs >= sp && ve <= ep) begin
        used[i] = 1'b0;
      end else if (vs < sp && ve > ep) begin
        f = first_free();
        if (f < 0) continue;
        start_pg[f] = ep;
        end_pg[f]   = ve;
        flags_q[f]  = flags_q[i];
        used[f]     = 1'b1;
        end_pg[i]   = sp;
      end else if (vs < sp) begin
        end_pg[i] = sp;
      end else begin
        start_pg[i] = ep;
      end
    end
    return did;
  endfunction

  function automatic bit gap_search(input logic [63:0] len_in, output logic [63:0] gap);
    logic [63:0] ln, lower, hint, cand, cend;
    int hit;
    gap = '0;
    if (len_in == 0 || len_in > ~PgMask) return 0;
    ln = (len_in + PgMask) & ~PgMask;
    if (heap_end_q > AllOnes - HeapGuard) return 0;
    lower = heap_end_q + HeapGuard;
    if (lower > AllOnes - ln) return 0;
    lower = lower + ln;
    hint = hint_q;
    for (int k = 0; k <= MaxRegions + 1; k++) begin
      if (hint < lower) return 0;
      cand = (hint - ln) & ~PgMask;
      cend = cand + ln;
      hit = -1;
      for (int i = 0; i < MaxRegions; i++) begin
        if (!used[i]) continue;
        if (cand < (end_pg[i] << PageShift) && cend > (start_pg[i] << PageShift))
          if (hit < 0 || start_pg[i] < start_pg[hit]) hit = i;
      end
      if (hit < 0) begin
        hint_q = cand;
        gap = cand;
        return 1;
      end
      hint = start_pg[hit] << PageShift;
    end
    return 0;
  endfunction

  function automatic bit span_covered(input logic [63:0] a, len);
    logic [63:0] last, cur;
    int i;
    if (len == 0) return 1;
    if (a > AllOnes - len) return 0;
    last = (a + len - 1) >> PageShift;
    cur = a >> PageShift;
    for (int k = 0; k <= MaxRegions; k++) begin
      i = owner_of(cur);
      if (i < 0) return 0;
      cur = end_pg[i];
      if (cur > last) return 1;
    end
    return 0;
  endfunction

  function automatic region_rsp_t table_response(input region_req_t q);
    region_rsp_t r;
    logic [63:0] gap;
    int i;
    r = '0;
    case (q.operation)
      OP_ADD:    r.success = region_add(q.address, q.end_address, q.region_flags);
      OP_REMOVE: r.success = region_remove(q.address, q.end_address);
      OP_FIND: begin
        i = owner_of(q.address >> PageShift);
        if (i >= 0) begin
          r.success        = 1'b1;
          r.result_address = start_pg[i] << PageShift;
          r.hit_end        = end_pg[i] << PageShift;
          r.hit_flags      = flags_q[i];
        end
      end
      OP_FREE: begin
        r.success = gap_search(q.length, gap);
        r.result_address = gap;
      end
      OP_RANGE:  r.success = span_covered(q.address, q.length);
      default: ;
    endcase
    return r;
  endfunction

  region_rsp_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MaxRegions; i++) begin
        used[i] = 1'b0;
        start_pg[i] = '0;
        end_pg[i] = '0;
        flags_q[i] = '0;
      end
      mmap_start_q = 64'd139637976727552;
      heap_end_q = '0;
      hint_q = mmap_start_q;
      want_q.delete();
      fails = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_MMAP_START) begin
          mmap_start_q = cfg_data;
          hint_q = cfg_data;
        end else begin
          heap_end_q = cfg_data;
        end
      end
      if (out_valid && out_ready) begin
        if (want_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected response transfer: %p", out_item);
        end else begin
          want = want_q.pop_front();
          if (want.success !== out_item.success ||
              want.result_address !== out_item.result_address ||
              want.hit_end !== out_item.hit_end ||
              want.hit_flags !== out_item.hit_flags) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: exp ok=%0b addr=%h end=%h fl=%h  got ok=%0b addr=%h end=%h fl=%h",
                       want.success, want.result_address, want.hit_end, want.hit_flags,
                       out_item.success, out_item.result_address, out_item.hit_end,
                       out_item.hit_flags);
          end
        end
      end
      if (in_valid && in_ready) want_q.push_back(table_response(in_item));
    end
  end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus top for the address region table
// Directed corner cases, then phases of random add/remove/find/free/range
// traffic around a moving address zone, with config changes between phases
// and random idle and stall bursts on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import art_pkg::*;
  import region_tb_pkg::*;

  localparam int          CycleLimit = 4_000_000;
  localparam logic [63:0] Page       = 64'h1000;
  localparam logic [63:0] TopPage    = 64'hFFFF_FFFF_FFFF_F000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_idx;
  logic [63:0] cfg_data;
  logic        quiet = 1'b0;
  int          fails, pending, cycles = 0, stall_left = 0;

  art_if #(.payload_t(region_req_t)) in_ch ();
  art_if #(.payload_t(region_rsp_t)) out_ch ();

  address_region_table uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  region_checker chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item(in_ch.payload),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_item(out_ch.payload),
    .fails(fails), .pending(pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // response side back-pressure in short bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send(input logic [2:0] op, input logic [63:0] a, e, len,
                      input logic [31:0] fl);
    region_req_t q;
    q = '{operation: op, address: a, end_address: e, length: len, region_flags: fl};
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= q;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] zone_addr(input logic [63:0] zone);
    logic [63:0] a;
    if ($urandom_range(0, 15) == 0) return rand64();
    a = zone + Page * $urandom_range(0, 63);
    if ($urandom_range(0, 7) == 0) a = a + $urandom_range(1, 4095);
    return a;
  endfunction

  function automatic logic [63:0] rand_len();
    case ($urandom_range(0, 15))
      0:       return rand64();
      1:       return ~64'd0 - $urandom_range(0, 8192);
      2:       return 64'd0;
      default: return $urandom_range(1, 16 * 4096);
    endcase
  endfunction

  logic [63:0] zone, a;
  logic [2:0]  op;

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_MMAP_START;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.payload <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    send(OP_ADD, 64'h0, Page, 0, 32'hFFFF_FFFF);
    send(OP_ADD, TopPage - Page, TopPage, 0, 32'h0);
    send(OP_ADD, 64'h5000, 64'h5000, 0, 32'h1);            // empty
    send(OP_ADD, 64'h5001, 64'h8000, 0, 32'h1);            // misaligned start
    send(OP_ADD, 64'h5000, 64'h8010, 0, 32'h1);            // misaligned end
    send(OP_ADD, 64'h5000, 64'h9000, 0, 32'hA5A5_5A5A);
    send(OP_ADD, 64'h8000, 64'hA000, 0, 32'h2);            // overlap
    send(OP_ADD, 64'h9000, 64'hC000, 0, 32'h3);            // adjacent
    send(OP_FIND, 64'h0FFF, 0, 0, 0);
    send(OP_FIND, ~64'd0 - 64'h1000, 0, 0, 0);
    send(OP_FIND, 64'h4FFF, 0, 0, 0);
    send(OP_RANGE, 64'h5800, 0, 64'h6000, 0);              // spans two regions
    send(OP_RANGE, 64'h123, 0, 0, 0);
    send(OP_RANGE, ~64'd0, 0, 64'd2, 0);                   // wraps
    send(OP_FREE, 0, 0, 0, 0);
    send(OP_FREE, 0, 0, ~64'd0, 0);
    send(OP_FREE, 0, 0, 64'h1801, 0);
    send(OP_REMOVE, 64'h6800, 64'h7001, 0, 0);             // split, unaligned
    send(OP_REMOVE, 64'hA000, 64'hA000, 0, 0);
    send(OP_BAD_LO, rand64(), rand64(), rand64(), $urandom());
    send(OP_BAD_HI, rand64(), rand64(), rand64(), $urandom());
    // fill the table, then a rejected add and a remove that trims a start
    for (int i = 0; i < 12; i++)
      send(OP_ADD, 64'h100000 + Page * 4 * i, 64'h102000 + Page * 4 * i, 0, i);
    send(OP_ADD, 64'h200000, 64'h201000, 0, 32'h7);
    send(OP_REMOVE, 64'h100800, 64'h101000, 0, 0);
    send(OP_REMOVE, 64'h0, ~64'd0, 0, 0);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: zone = 64'h7EFF_FFFC_0000;
        1: zone = 64'h0;
        default: zone = 64'hFFFF_FFFF_FFFC_0000;
      endcase
      case (ph)
        1: write_reg(CFG_MMAP_START, 64'h0);
        2: write_reg(CFG_MMAP_START, ~64'd0);
        default: write_reg(CFG_MMAP_START, zone + Page * $urandom_range(32, 80));
      endcase
      case (ph)
        0: write_reg(CFG_HEAP_END, 64'h0);
        4: write_reg(CFG_HEAP_END, ~64'd0);
        default: write_reg(CFG_HEAP_END, zone - HeapGuard - Page * $urandom_range(0, 40));
      endcase
      quiet = (ph == 5);
      for (int n = 0; n < 270; n++) begin
        if (n == 135) drain();   // let everything land before continuing
        a = zone_addr(zone);
        op = ($urandom_range(0, 49) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
        case (op)
          OP_ADD:
            send(op, a, ($urandom_range(0, 9) == 0) ? rand64()
                 : a + Page * $urandom_range(1, 8), rand64(), $urandom());
          OP_REMOVE:
            send(op, a, ($urandom_range(0, 19) == 0) ? a + Page * 64
                 : a + $urandom_range(0, 6 * 4096), rand64(), $urandom());
          default:
            send(op, a, rand64(), rand_len(), $urandom());
        endcase
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (fails == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
